### rtl/core/mts_pkg.sv
`default_nettype none
package mts_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 11;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic latch;   // capture the incoming item
		logic exec;    // apply the operation
		logic load;    // reload tops from the stores after a pop
	} mts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_fetch;  // pop taken, new tops come from the stores
	} mts_stat_t;

endpackage
`default_nettype wire

### rtl/core/mts_ram.sv
`default_nettype none
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/mts_ctrl.sv
`default_nettype none
module mts_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire mts_pkg::mts_stat_t  stat,
	output logic                     busy,
	output mts_pkg::mts_cmd_t        cmd
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		LOAD
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
						busy_q  <= 1'b1;
					end
				end
				EXEC: begin
					if (stat.need_fetch) begin
						state_q <= LOAD;
						busy_q  <= 1'b1;
					end else begin
						state_q <= IDLE;
						busy_q  <= 1'b0;
					end
				end
				LOAD: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy      = busy_q;
	assign cmd.latch = (state_q == IDLE) && start;
	assign cmd.exec  = (state_q == EXEC);
	assign cmd.load  = (state_q == LOAD);

endmodule
`default_nettype wire

### rtl/core/mts_datapath.sv
`default_nettype none
module mts_datapath #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mts_pkg::mts_cmd_t                  cmd,
	input  wire logic [1:0]                         action,
	input  wire logic signed [mts_pkg::DATA_W-1:0]  push_value,
	output mts_pkg::mts_stat_t                      stat,
	output logic                                    done,
	output logic signed [mts_pkg::DATA_W-1:0]       top_value,
	output logic signed [mts_pkg::DATA_W-1:0]       min_value,
	output logic [mts_pkg::COUNT_W-1:0]             element_count,
	output logic                                    is_empty,
	output logic [1:0]                              status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = mts_pkg::DATA_W;

	// captured item
	logic [1:0]    act_q;
	logic [DW-1:0] val_q;

	// stack pointers and cached tops
	logic [CW-1:0] vcount_q, mcount_q;
	logic [DW-1:0] top_q, min_q;

	// result registers
	logic          done_q;
	logic [DW-1:0] top_out_q, min_out_q;
	logic [CW-1:0] count_out_q;
	logic [1:0]    status_q;

	logic [CW-1:0] vcount_n, mcount_n, vc_m2, mc_m2;
	logic [DW-1:0] top_n, min_n;
	logic [1:0]    status_n;
	logic          v_we, m_we, fetch;
	logic [DW-1:0] rd_v, rd_m;

	// result source
	logic [CW-1:0] r_vc, r_mc;
	logic [DW-1:0] r_top, r_min;

	always_comb begin
		vcount_n = vcount_q;
		mcount_n = mcount_q;
		top_n    = top_q;
		min_n    = min_q;
		status_n = mts_pkg::ST_OK;
		v_we     = 1'b0;
		m_we     = 1'b0;
		fetch    = 1'b0;
		unique case (act_q)
			mts_pkg::ACT_PUSH: begin
				if (vcount_q == CW'(STACK_DEPTH)) begin
					status_n = mts_pkg::ST_PUSH_FULL;
				end else begin
					v_we     = 1'b1;
					vcount_n = vcount_q + CW'(1);
					top_n    = val_q;
					if ((mcount_q == '0 || $signed(val_q) <= $signed(min_q))
							&& mcount_q != CW'(STACK_DEPTH)) begin
						m_we     = 1'b1;
						mcount_n = mcount_q + CW'(1);
						min_n    = val_q;
					end
				end
			end
			mts_pkg::ACT_POP: begin
				if (vcount_q == '0) begin
					status_n = mts_pkg::ST_POP_EMPTY;
				end else begin
					fetch    = 1'b1;
					vcount_n = vcount_q - CW'(1);
					if (mcount_q != '0 && min_q == top_q) begin
						mcount_n = mcount_q - CW'(1);
					end
				end
			end
			default: ;  // read and unused code: no change
		endcase
	end

	assign vc_m2 = vcount_q - CW'(2);
	assign mc_m2 = (mcount_n == mcount_q) ? mcount_q - CW'(1) : mcount_q - CW'(2);

	mts_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (cmd.exec && v_we),
		.waddr (vcount_q[AW-1:0]),
		.wdata (val_q),
		.raddr (vc_m2[AW-1:0]),
		.rdata (rd_v)
	);

	mts_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (cmd.exec && m_we),
		.waddr (mcount_q[AW-1:0]),
		.wdata (val_q),
		.raddr (mc_m2[AW-1:0]),
		.rdata (rd_m)
	);

	always_comb begin
		if (cmd.load) begin
			r_vc  = vcount_q;
			r_mc  = mcount_q;
			r_top = rd_v;
			r_min = rd_m;
		end else begin
			r_vc  = vcount_n;
			r_mc  = mcount_n;
			r_top = top_n;
			r_min = min_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= action;
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			top_q    <= top_n;
			min_q    <= min_n;
			status_q <= status_n;
		end else if (cmd.load) begin
			top_q    <= rd_v;
			min_q    <= rd_m;
			status_q <= mts_pkg::ST_OK;
		end
		if ((cmd.exec && !fetch) || cmd.load) begin
			top_out_q   <= (r_vc != '0) ? r_top : '0;
			min_out_q   <= (r_vc != '0 && r_mc != '0) ? r_min : '0;
			count_out_q <= r_vc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			mcount_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (cmd.exec && !fetch) || cmd.load;
			if (cmd.exec) begin
				vcount_q <= vcount_n;
				mcount_q <= mcount_n;
			end
		end
	end

	assign stat.need_fetch = cmd.exec && fetch;
	assign done            = done_q;
	assign top_value       = top_out_q;
	assign min_value       = min_out_q;
	assign element_count   = mts_pkg::COUNT_W'(count_out_q);
	assign is_empty        = (count_out_q == '0);
	assign status          = status_q;

	// minimum stack never outgrows the value stack
	a_min_le_val: assert property (@(posedge clk) disable iff (!arst_n)
		mcount_q <= vcount_q)
		else $error("minimum stack deeper than value stack");

	// the two stacks empty together
	a_empty_together: assert property (@(posedge clk) disable iff (!arst_n)
		(vcount_q == '0) == (mcount_q == '0))
		else $error("stacks disagree on emptiness");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

endmodule
`default_nettype wire

### rtl/core/min_tracking_stack.sv
`default_nettype none
// A push or read is captured, then executed, and its result strobe is registered from the
//   execute state; a pop adds a load state (the pop cycle issues store reads at the new tops,
//   the next cycle loads them). A new item is taken only while idle, so each item finishes
//   before the next; the pop's load state is set by the registered read port of both stores.
// Reset (arst_n low): both stacks empty, no result pending; store contents are left as is.
// Results appear on the result ports for one cycle with done high; the receiver cannot stall.
module min_tracking_stack #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         action,
	input  wire logic signed [mts_pkg::DATA_W-1:0]  push_value,
	output logic                                    done,
	output logic signed [mts_pkg::DATA_W-1:0]       top_value,
	output logic signed [mts_pkg::DATA_W-1:0]       min_value,
	output logic [mts_pkg::COUNT_W-1:0]             element_count,
	output logic                                    is_empty,
	output logic [1:0]                              status
);

	// command and status between the sequencer and the stack datapath
	mts_pkg::mts_cmd_t  cmd;
	mts_pkg::mts_stat_t stat;

	// sequencer: idle, execute, and a load state after a pop from a non-empty stack
	mts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: pointers, cached tops, both stores and the result registers
	mts_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.push_value    (push_value),
		.stat          (stat),
		.done          (done),
		.top_value     (top_value),
		.min_value     (min_value),
		.element_count (element_count),
		.is_empty      (is_empty),
		.status        (status)
	);

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	// a result only follows work, and is shown once the block is free
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without preceding work");

	// an empty stack reports zero top and minimum
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> top_value == '0 && min_value == '0)
		else $error("empty stack reports non-zero values");

endmodule
`default_nettype wire
